[design/dbom_pkg.sv]
`default_nettype none
package dbom_pkg;

	// Input modes.
	typedef enum logic [1:0] {
		MODE_BOOK   = 2'd0,
		MODE_CREATE = 2'd1,
		MODE_MODIFY = 2'd2,
		MODE_CANCEL = 2'd3
	} mode_t;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_ACK   = 2'd0,
		KIND_ORDER = 2'd1,
		KIND_TRADE = 2'd2,
		KIND_POS   = 2'd3
	} kind_t;

	localparam logic [1:0] RSN_OK = 2'd0;
	localparam logic [1:0] RSN_INVALID_SIDE = 2'd1;
	localparam logic [1:0] RSN_NOT_SUPPORTED = 2'd2;

	localparam logic [46:0] POS_MAX = {47{1'b1}};

	// Classified command passed from the front part to the back part.
	typedef struct packed {
		logic        match;     // walk the book after the ack
		logic [1:0]  reason;
		logic [31:0] client_ref;
		logic [1:0]  account;
		logic [1:0]  exchange;
		logic [3:0]  symbol;
		logic        side;
		logic [31:0] price;
		logic [31:0] quantity;
	} cmd_t;

endpackage
`default_nettype wire

[design/depth_book_order_matcher_unit.sv]
// Order matcher against a per-symbol depth book of up to eight levels. After reset, busy
// stays high while the book and position memories are cleared. Orders, modify
// and cancel requests enter a two-entry queue, and busy is high while it is full. A book
// write is held off by busy until the queue is empty and the matcher is idle, so levels never
// change under an order in flight; it produces no result. The matcher takes an order from
// the queue and sends the ack, then does a read, an evaluate, a trade and a position step
// for each crossed level, set by the registered read of the level memory and the shared
// address of the position memory. Results come out one per strobe cycle and cannot be held off.
`default_nettype none
module depth_book_order_matcher_unit #(
	parameter int DEPTH = 8,
	parameter int NUM_SYMBOLS = 16,
	parameter int NUM_ACCOUNTS = 4,
	parameter int NUM_EXCHANGES = 4
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire [1:0]   mode,
	input  wire [3:0]   symbol,
	input  wire [1:0]   exchange,
	input  wire [1:0]   account,
	input  wire [31:0]  client_ref,
	input  wire [1:0]   side,
	input  wire [2:0]   level,
	input  wire [31:0]  price,
	input  wire [31:0]  quantity,
	input  wire [31:0]  offer_price,
	input  wire [31:0]  ask_qty,
	output logic        strobe,
	output logic [1:0]  msg_kind,
	output logic [1:0]  reject_reason,
	output logic [31:0] out_client_ref,
	output logic [1:0]  out_account,
	output logic [1:0]  out_exchange,
	output logic [3:0]  out_symbol,
	output logic        out_side,
	output logic        ord_state,
	output logic [31:0] fill_qty,
	output logic [31:0] remaining_qty,
	output logic [47:0] value,
	output logic        last
);

	logic           take;
	logic           bk_we;
	logic [3:0]     bk_sym;
	logic [2:0]     bk_lvl;
	logic [127:0]   bk_data;
	logic           cmd_push;
	logic           cmd_pop;
	logic           back_idle;
	dbom_pkg::cmd_t cmd_in;
	dbom_pkg::cmd_t fifo_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;
	logic [6:0]     rd_addr;
	logic [127:0]   rd_data;
	logic [8:0]     pos_addr;
	logic [46:0]    pos_rdata;
	logic           pos_we;
	logic [46:0]    pos_wdata;
	logic [8:0]     pclr_q;
	logic           clr_q;

	// Busy while the queue is full, the memories are being cleared, or a book write
	// waits for the orders ahead of it to finish.
	assign busy = (cnt_q == 2'd2) || clr_q
		|| ((mode == dbom_pkg::MODE_BOOK) && ((cnt_q != 2'd0) || !back_idle));
	assign take = start && !busy;

	dbom_front #(
		.DEPTH(DEPTH), .NUM_SYMBOLS(NUM_SYMBOLS),
		.NUM_ACCOUNTS(NUM_ACCOUNTS), .NUM_EXCHANGES(NUM_EXCHANGES)
	) u_front (
		.clk, .arst_n, .take, .mode, .symbol, .exchange, .account, .client_ref,
		.side, .level, .price, .quantity, .offer_price, .ask_qty,
		.bk_we, .bk_sym, .bk_lvl, .bk_data,
		.cmd_push, .cmd(cmd_in)
	);

	// Two-entry command queue between front and back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (cmd_push) wr_q <= !wr_q;
			if (cmd_pop)  rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(cmd_push) - 2'(cmd_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_push) begin
			fifo_q[wr_q] <= cmd_in;
		end
	end

	// Book memory: a level never written is kept out of the walk by the present bit,
	// since orders walk only symbols whose book was written; unwritten levels of
	// a present symbol are cleared by the sweep below and read as zero.
	dbom_ram #(.WIDTH(128), .DEPTH(128)) u_book (
		.clk,
		.we(clr_q || bk_we),
		.waddr(clr_q ? pclr_q[6:0] : 7'({bk_sym, bk_lvl})),
		.wdata(clr_q ? 128'd0 : bk_data),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	dbom_ram #(.WIDTH(47), .DEPTH(512)) u_pos (
		.clk,
		.we(clr_q || pos_we),
		.waddr(clr_q ? pclr_q : pos_addr),
		.wdata(clr_q ? 47'd0 : pos_wdata),
		.raddr(pos_addr),
		.rdata(pos_rdata)
	);

	// Clearing pass after reset: it walks all 512 position addresses and clears the book through their low bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pclr_q <= '0;
			clr_q  <= 1'b1;
		end else if (clr_q) begin
			pclr_q <= pclr_q + 1'b1;
			if (pclr_q == 9'h1FF) clr_q <= 1'b0;
		end
	end

	dbom_back #(.DEPTH(DEPTH)) u_back (
		.clk, .arst_n,
		.cmd_valid(cnt_q != 2'd0),
		.cmd(fifo_q[rd_q]),
		.cmd_pop, .idle(back_idle), .rd_addr, .rd_data, .pos_addr, .pos_rdata, .pos_we,
		.pos_wdata, .strobe, .msg_kind, .reject_reason, .out_client_ref, .out_account,
		.out_exchange, .out_symbol, .out_side, .ord_state, .fill_qty, .remaining_qty,
		.value, .last
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> !cmd_push)
		else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> !cmd_pop)
		else $error("queue underflow");
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !take)
		else $error("item taken during clear");

endmodule
`default_nettype wire

[design/dbom_ram.sv]
`default_nettype none
module dbom_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Single write port, registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[design/dbom_front.sv]
`default_nettype none
module dbom_front #(
	parameter int DEPTH = 8,
	parameter int NUM_SYMBOLS = 16,
	parameter int NUM_ACCOUNTS = 4,
	parameter int NUM_EXCHANGES = 4
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                take,
	input  wire [1:0]          mode,
	input  wire [3:0]          symbol,
	input  wire [1:0]          exchange,
	input  wire [1:0]          account,
	input  wire [31:0]         client_ref,
	input  wire [1:0]          side,
	input  wire [2:0]          level,
	input  wire [31:0]         price,
	input  wire [31:0]         quantity,
	input  wire [31:0]         offer_price,
	input  wire [31:0]         ask_qty,
	// Book write port.
	output logic               bk_we,
	output logic [3:0]         bk_sym,
	output logic [2:0]         bk_lvl,
	output logic [127:0]       bk_data,
	// Command queue push.
	output logic               cmd_push,
	output dbom_pkg::cmd_t     cmd
);

	logic [15:0] present_q;
	logic        lvl_ok;
	logic        sym_ok;
	logic        idx_ok;

	assign lvl_ok = 32'(level) < DEPTH;
	assign sym_ok = 32'(symbol) < NUM_SYMBOLS;
	assign idx_ok = sym_ok && (32'(account) < NUM_ACCOUNTS)
		&& (32'(exchange) < NUM_EXCHANGES);

	// Book writes go straight to the level memory.
	assign bk_we   = take && (mode == dbom_pkg::MODE_BOOK) && lvl_ok && sym_ok;
	assign bk_sym  = symbol;
	assign bk_lvl  = level;
	assign bk_data = {price, quantity, offer_price, ask_qty};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
		end else if (bk_we) begin
			present_q[symbol] <= 1'b1;
		end
	end

	// Classify orders and requests.
	always_comb begin
		cmd_push       = take && (mode != dbom_pkg::MODE_BOOK);
		cmd.client_ref = client_ref;
		cmd.account    = account;
		cmd.exchange   = exchange;
		cmd.symbol     = symbol;
		cmd.price      = price;
		cmd.quantity   = quantity;
		cmd.side       = 1'b0;
		cmd.match      = 1'b0;
		cmd.reason     = dbom_pkg::RSN_OK;
		if (mode != dbom_pkg::MODE_CREATE) begin
			cmd.reason = dbom_pkg::RSN_NOT_SUPPORTED;
		end else if (side[1]) begin
			cmd.reason = dbom_pkg::RSN_INVALID_SIDE;
		end else begin
			cmd.side  = side[0];
			cmd.match = idx_ok && present_q[symbol] && (quantity != 32'd0);
		end
	end

endmodule
`default_nettype wire

[design/dbom_back.sv]
`default_nettype none
module dbom_back #(
	parameter int DEPTH = 8
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cmd_valid,
	input  dbom_pkg::cmd_t     cmd,
	output logic               cmd_pop,
	output logic               idle,
	output logic [6:0]         rd_addr,
	input  wire [127:0]        rd_data,
	output logic [8:0]         pos_addr,
	input  wire [46:0]         pos_rdata,
	output logic               pos_we,
	output logic [46:0]        pos_wdata,
	output logic               strobe,
	output logic [1:0]         msg_kind,
	output logic [1:0]         reject_reason,
	output logic [31:0]        out_client_ref,
	output logic [1:0]         out_account,
	output logic [1:0]         out_exchange,
	output logic [3:0]         out_symbol,
	output logic               out_side,
	output logic               ord_state,
	output logic [31:0]        fill_qty,
	output logic [31:0]        remaining_qty,
	output logic [47:0]        value,
	output logic               last
);

	localparam int LW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_ACK   = 6'b000010,
		ST_READ  = 6'b000100,
		ST_EVAL  = 6'b001000,
		ST_TRADE = 6'b010000,
		ST_POS   = 6'b100000
	} state_t;

	state_t          state_q;
	dbom_pkg::cmd_t  c_q;
	logic [LW:0]     lvl_q;
	logic [LW:0]     lvl_rd;
	logic [31:0]     left_q;
	logic [31:0]     fill_q;
	logic [31:0]     lp_q;
	logic [31:0]     lp;
	logic [31:0]     lq;
	logic            crosses;
	logic [31:0]     fill;
	logic [31:0]     left_n;
	logic [47:0]     psum;
	logic            more;

	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;
	assign idle    = (state_q == ST_IDLE);

	// The read cycle fetches the current level; the other cycles fetch the next one,
	// so the position update knows whether the walk goes on.
	assign lvl_rd  = (state_q == ST_READ) ? lvl_q : lvl_q + 1'b1;
	assign rd_addr = 7'({c_q.symbol, 3'(lvl_rd)});
	assign pos_addr = {c_q.account, c_q.exchange, c_q.symbol, c_q.side};

	// Opposite side of the level just read.
	assign lp      = c_q.side ? rd_data[127:96] : rd_data[63:32];
	assign lq      = c_q.side ? rd_data[95:64]  : rd_data[31:0];
	assign crosses = c_q.side ? ($signed(lp) >= $signed(c_q.price))
		: ($signed(lp) <= $signed(c_q.price));
	assign fill   = (lq >= left_q) ? left_q : lq;
	assign left_n = left_q - fill;
	assign psum   = {1'b0, pos_rdata} + {16'd0, fill_q};
	assign pos_wdata = psum[47] ? dbom_pkg::POS_MAX : psum[46:0];
	assign pos_we = (state_q == ST_POS);
	assign more = (left_q != 32'd0) && ((32'(lvl_q) + 32'd1) < DEPTH) && crosses;

	// Sequencer: ack, then read, evaluate, trade, position per crossed level; any uncrossed level ends the walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			strobe  <= 1'b0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						state_q <= ST_ACK;
					end
				end
				ST_ACK: begin
					strobe  <= 1'b1;
					state_q <= c_q.match ? ST_READ : ST_IDLE;
				end
				ST_READ: state_q <= ST_EVAL;
				ST_EVAL: begin
					if (crosses) begin
						strobe  <= 1'b1;
						state_q <= ST_TRADE;
					end else begin
						strobe  <= (lvl_q == '0);
						state_q <= ST_IDLE;
					end
				end
				ST_TRADE: begin
					strobe  <= 1'b1;
					state_q <= ST_POS;
				end
				ST_POS: begin
					strobe  <= 1'b1;
					state_q <= more ? ST_READ : ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload and walk registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				c_q    <= cmd;
				lvl_q  <= '0;
				left_q <= cmd.quantity;
			end
			ST_ACK: begin
				msg_kind      <= dbom_pkg::KIND_ACK;
				reject_reason <= c_q.reason;
				ord_state     <= 1'b0;
				fill_qty      <= '0;
				remaining_qty <= '0;
				value         <= '0;
				last          <= !c_q.match;
			end
			ST_READ: ;
			ST_EVAL: begin
				msg_kind      <= dbom_pkg::KIND_ORDER;
				reject_reason <= dbom_pkg::RSN_OK;
				value         <= '0;
				last          <= !crosses;
				ord_state     <= !crosses;
				fill_qty      <= crosses ? fill : 32'd0;
				remaining_qty <= crosses ? left_n : c_q.quantity;
				fill_q        <= fill;
				lp_q          <= lp;
				if (crosses) begin
					left_q <= left_n;
				end
			end
			ST_TRADE: begin
				msg_kind      <= dbom_pkg::KIND_TRADE;
				ord_state     <= 1'b0;
				remaining_qty <= '0;
				value         <= 48'($signed(lp_q));
				last          <= 1'b0;
			end
			ST_POS: begin
				msg_kind <= dbom_pkg::KIND_POS;
				fill_qty <= '0;
				value    <= {1'b0, pos_wdata};
				last     <= !more;
				lvl_q    <= lvl_q + 1'b1;
			end
			default: ;
		endcase
	end

	assign out_client_ref = c_q.client_ref;
	assign out_account    = c_q.account;
	assign out_exchange   = c_q.exchange;
	assign out_symbol     = c_q.symbol;
	assign out_side       = c_q.side;

	// The ack is always the first result after a command is taken.
	a_ack_first: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && cmd_valid) |=> ##1 (strobe && msg_kind == dbom_pkg::KIND_ACK))
		else $error("ack not first");
	// A position update always follows a trade update.
	a_pos_after_trade: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POS) |-> (strobe && msg_kind == dbom_pkg::KIND_TRADE)
		##1 (strobe && msg_kind == dbom_pkg::KIND_POS))
		else $error("position order");
	// The walk never goes past the last level.
	a_lvl_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL) |-> (32'(lvl_q) < DEPTH))
		else $error("level overrun");

endmodule
`default_nettype wire
